FILE: hdl/pcff_pkg.sv
package pcff_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int TS_W      = 17;
    localparam int MUL_W     = DATA_W + 1;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int MUL_STEPS = MUL_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);
    localparam int SAT_W     = PROD_W - FRAC_W + 1;
    localparam int REG_IDX_W = 3;

    typedef logic signed [DATA_W-1:0] q16_t;
    typedef logic [REG_IDX_W-1:0]     reg_idx_t;

    localparam reg_idx_t REG_PROP_GAIN   = 3'd0;
    localparam reg_idx_t REG_INT_GAIN    = 3'd1;
    localparam reg_idx_t REG_OUT_MIN     = 3'd2;
    localparam reg_idx_t REG_OUT_MAX     = 3'd3;
    localparam reg_idx_t REG_FF_GAIN     = 3'd4;
    localparam reg_idx_t REG_FF_MIN      = 3'd5;
    localparam reg_idx_t REG_FF_MAX      = 3'd6;
    localparam reg_idx_t REG_SAMPLE_TIME = 3'd7;

    localparam logic [TS_W-1:0] SAMPLE_TIME_RST = 17'd66;

    typedef struct packed {
        q16_t            prop_gain;
        q16_t            int_gain;
        q16_t            out_min;
        q16_t            out_max;
        q16_t            ff_gain;
        q16_t            ff_min;
        q16_t            ff_max;
        logic [TS_W-1:0] sample_time;
    } pcff_cfg_t;

    // which product the shared multiplier is working on
    typedef logic [1:0] mul_sel_t;
    localparam mul_sel_t MUL_PROP = 2'd0;
    localparam mul_sel_t MUL_FF   = 2'd1;
    localparam mul_sel_t MUL_GAIN = 2'd2;
    localparam mul_sel_t MUL_INCR = 2'd3;

    localparam logic signed [SAT_W-1:0] Q_MAX = 51'sh7FFF_FFFF;
    localparam logic signed [SAT_W-1:0] Q_MIN = -51'sh8000_0000;

    function automatic q16_t sat32(logic signed [SAT_W-1:0] v);
        q16_t r;
        if (v > Q_MAX)
        begin
            r = Q_MAX[DATA_W-1:0];
        end
        else if (v < Q_MIN)
        begin
            r = Q_MIN[DATA_W-1:0];
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/pcff_if.sv
interface pcff_upd_if;
    import pcff_pkg::*;

    logic valid;
    logic ready;
    logic cmd;
    q16_t setpoint;
    q16_t measurement;

    modport source (output valid, cmd, setpoint, measurement, input ready);
    modport sink   (input valid, cmd, setpoint, measurement, output ready);
endinterface

interface pcff_res_if;
    import pcff_pkg::*;

    logic valid;
    logic ready;
    q16_t drive;

    modport source (output valid, drive, input ready);
    modport sink   (input valid, drive, output ready);
endinterface

FILE: hdl/pcff_regs.sv
module pcff_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  pcff_pkg::reg_idx_t               cfg_index,
    input  logic [pcff_pkg::DATA_W-1:0]      cfg_data,
    output pcff_pkg::pcff_cfg_t              cfg
);
    import pcff_pkg::*;

    pcff_cfg_t cfg_reg;
    pcff_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:   cfg_next.prop_gain   = cfg_data;
                REG_INT_GAIN:    cfg_next.int_gain    = cfg_data;
                REG_OUT_MIN:     cfg_next.out_min     = cfg_data;
                REG_OUT_MAX:     cfg_next.out_max     = cfg_data;
                REG_FF_GAIN:     cfg_next.ff_gain     = cfg_data;
                REG_FF_MIN:      cfg_next.ff_min      = cfg_data;
                REG_FF_MAX:      cfg_next.ff_max      = cfg_data;
                REG_SAMPLE_TIME: cfg_next.sample_time = cfg_data[TS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{sample_time: SAMPLE_TIME_RST, default: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/pcff_smul.sv
// Radix-2 shift-add signed multiplier: one multiplier bit per cycle,
// the sign bit's partial product is subtracted.
module pcff_smul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [pcff_pkg::MUL_W-1:0]   a,
    input  logic signed [pcff_pkg::MUL_W-1:0]   b,
    output logic                                busy,
    output logic                                done,
    output logic signed [pcff_pkg::PROD_W-1:0]  product
);
    import pcff_pkg::*;

    logic signed [PROD_W-1:0] mcand_reg, mcand_next;
    logic [MUL_W-1:0]         mplier_reg, mplier_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic [MUL_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic                     last;
    logic signed [PROD_W-1:0] addend;

    assign last   = (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1));
    assign addend = mplier_reg[0] ? mcand_reg : '0;

    always_comb
    begin
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            mcand_next  = PROD_W'(a);
            mplier_next = b;
            acc_next    = '0;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next    = last ? (acc_reg - addend) : (acc_reg + addend);
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = acc_reg;

endmodule

FILE: hdl/pi_controller_ff_antiwindup.sv
// PI controller with clamped setpoint feedforward and trapezoidal integrator
// anti-windup, signed Q16.16. An update beat runs four products (proportional,
// feedforward, step gain, integrator increment) one after another through a
// single bit-serial multiplier that retires one multiplier bit per cycle,
// followed by the integrator update, limit clamp and output sum states. A new
// update is accepted only once the previous beat is back in idle. A clear beat
// skips the products and the integrator update. The result sits in an output
// register, so a new beat is taken while the previous result waits.
// Configuration writes are taken at any time but belong in idle periods.
module pi_controller_ff_antiwindup (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  pcff_pkg::reg_idx_t           cfg_index,
    input  logic [pcff_pkg::DATA_W-1:0]  cfg_data,
    pcff_upd_if.sink                     update,
    pcff_res_if.source                   result
);
    import pcff_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_ACC  = 5'b00100,
        S_LIM  = 5'b01000,
        S_SUM  = 5'b10000
    } state_t;

    pcff_cfg_t cfg;

    state_t   state_reg, state_next;
    mul_sel_t mul_sel_reg, mul_sel_next;
    logic     mul_start_reg, mul_start_next;
    logic     clr_reg, clr_next;
    logic     out_valid_reg, out_valid_next;
    q16_t     sp_reg, sp_next;
    q16_t     err_reg, err_next;
    q16_t     last_reg, last_next;
    q16_t     g_reg, g_next;
    q16_t     prop_reg, prop_next;
    q16_t     ff_reg, ff_next;
    q16_t     acc_reg, acc_next;
    q16_t     lmax_reg, lmax_next;
    q16_t     lmin_reg, lmin_next;
    q16_t     drive_reg, drive_next;
    logic signed [PROD_W-FRAC_W-1:0] incr_reg, incr_next;

    logic                      mul_busy;
    logic                      mul_done;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  mul_product;

    logic signed [DATA_W:0]          diff;
    logic signed [DATA_W:0]          err_sum;
    logic signed [PROD_W-FRAC_W-1:0] prod_q;
    q16_t                            prod_sat;
    q16_t                            ff_clamped;
    logic signed [SAT_W-1:0]         acc_sum;
    logic signed [DATA_W+1:0]        dhi;
    logic signed [DATA_W+1:0]        dlo;
    logic signed [DATA_W:0]          hp;
    logic signed [DATA_W:0]          lp;
    q16_t                            acc_clamped;
    logic signed [DATA_W+1:0]        y_sum;
    q16_t                            y_clamped;
    logic                            out_free;

    pcff_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (mul_sel_reg)
            MUL_PROP:
            begin
                mul_a = MUL_W'(cfg.prop_gain);
                mul_b = MUL_W'(err_reg);
            end
            MUL_FF:
            begin
                mul_a = MUL_W'(cfg.ff_gain);
                mul_b = MUL_W'(sp_reg);
            end
            MUL_GAIN:
            begin
                mul_a = MUL_W'(cfg.sample_time);
                mul_b = MUL_W'(cfg.int_gain);
            end
            MUL_INCR:
            begin
                mul_a = MUL_W'(g_reg);
                mul_b = err_sum;
            end
            default: ;
        endcase
    end

    pcff_smul u_smul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_product)
    );

    assign diff    = (DATA_W+1)'(update.setpoint) - (DATA_W+1)'(update.measurement);
    assign err_sum = (DATA_W+1)'(err_reg) + (DATA_W+1)'(last_reg);

    // products are Q34.32; drop 16 fraction bits (floor)
    assign prod_q   = mul_product[PROD_W-1:FRAC_W];
    assign prod_sat = sat32(SAT_W'(prod_q));

    always_comb
    begin
        if (prod_sat > cfg.ff_max)
        begin
            ff_clamped = cfg.ff_max;
        end
        else if (prod_sat < cfg.ff_min)
        begin
            ff_clamped = cfg.ff_min;
        end
        else
        begin
            ff_clamped = prod_sat;
        end
    end

    assign acc_sum = SAT_W'(acc_reg) + SAT_W'(incr_reg);

    assign dhi = (DATA_W+2)'(cfg.out_max) - (DATA_W+2)'(prop_reg) - (DATA_W+2)'(ff_reg);
    assign dlo = (DATA_W+2)'(cfg.out_min) - (DATA_W+2)'(prop_reg) - (DATA_W+2)'(ff_reg);
    assign hp  = (DATA_W+1)'(cfg.out_max) - (DATA_W+1)'(prop_reg);
    assign lp  = (DATA_W+1)'(cfg.out_min) - (DATA_W+1)'(prop_reg);

    // when the limits cross, a value above the upper limit takes it, any other takes the lower
    always_comb
    begin
        if (acc_reg > lmax_reg)
        begin
            acc_clamped = lmax_reg;
        end
        else if (acc_reg < lmin_reg)
        begin
            acc_clamped = lmin_reg;
        end
        else
        begin
            acc_clamped = acc_reg;
        end
    end

    assign y_sum = (DATA_W+2)'(prop_reg) + (DATA_W+2)'(ff_reg) + (DATA_W+2)'(acc_reg);

    always_comb
    begin
        if (y_sum > (DATA_W+2)'(cfg.out_max))
        begin
            y_clamped = cfg.out_max;
        end
        else if (y_sum < (DATA_W+2)'(cfg.out_min))
        begin
            y_clamped = cfg.out_min;
        end
        else
        begin
            y_clamped = y_sum[DATA_W-1:0];
        end
    end

    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next     = state_reg;
        mul_sel_next   = mul_sel_reg;
        mul_start_next = 1'b0;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        sp_next        = sp_reg;
        err_next       = err_reg;
        last_next      = last_reg;
        g_next         = g_reg;
        prop_next      = prop_reg;
        ff_next        = ff_reg;
        acc_next       = acc_reg;
        lmax_next      = lmax_reg;
        lmin_next      = lmin_reg;
        drive_next     = drive_reg;
        incr_next      = incr_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (update.valid)
                begin
                    clr_next = update.cmd;
                    sp_next  = update.setpoint;
                    if (update.cmd)
                    begin
                        acc_next   = '0;
                        last_next  = '0;
                        state_next = S_SUM;
                    end
                    else
                    begin
                        err_next       = sat32(SAT_W'(diff));
                        mul_sel_next   = MUL_PROP;
                        mul_start_next = 1'b1;
                        state_next     = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    case (mul_sel_reg)
                        MUL_PROP: prop_next = prod_sat;
                        MUL_FF:   ff_next   = ff_clamped;
                        // the extra bit of shift folds in the trapezoid's half
                        MUL_GAIN: g_next    = mul_product[DATA_W+TS_W-1:TS_W];
                        MUL_INCR: incr_next = prod_q;
                        default: ;
                    endcase
                    if (mul_sel_reg == MUL_INCR)
                    begin
                        state_next = S_ACC;
                    end
                    else
                    begin
                        mul_sel_next   = mul_sel_reg + 1'b1;
                        mul_start_next = 1'b1;
                    end
                end
            end
            S_ACC:
            begin
                acc_next   = sat32(acc_sum);
                lmax_next  = (dhi > 0) ? sat32(SAT_W'(hp)) : '0;
                lmin_next  = (dlo < 0) ? sat32(SAT_W'(lp)) : '0;
                state_next = S_LIM;
            end
            S_LIM:
            begin
                acc_next   = acc_clamped;
                last_next  = err_reg;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    drive_next     = clr_reg ? '0 : y_clamped;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mul_sel_reg   <= MUL_PROP;
            mul_start_reg <= 1'b0;
            clr_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            last_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mul_sel_reg   <= mul_sel_next;
            mul_start_reg <= mul_start_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sp_reg    <= sp_next;
        err_reg   <= err_next;
        g_reg     <= g_next;
        prop_reg  <= prop_next;
        ff_reg    <= ff_next;
        lmax_reg  <= lmax_next;
        lmin_reg  <= lmin_next;
        drive_reg <= drive_next;
        incr_reg  <= incr_next;
    end

    assign update.ready = (state_reg == S_IDLE);
    assign result.valid = out_valid_reg;
    assign result.drive = drive_reg;

    a_mul_quiet_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !mul_busy)
        else $error("multiplier busy while controller idle");

    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == S_MUL)
        else $error("multiplier finished outside multiply phase");

    a_integ_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIM && lmin_reg <= lmax_reg)
        |=> (acc_reg <= lmax_reg && acc_reg >= lmin_reg))
        else $error("integrator outside anti-windup limits");

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM && clr_reg && out_free)
        |=> (result.valid && result.drive == '0))
        else $error("clear did not return zero drive");

endmodule
